[hdl/command_line_tokenizer_core_defines.svh]
// Assertion macros shared by the command line tokenizer modules.
// No dependencies; the asserting files include it by name.
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge while the block is out of reset.
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define CLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/clt_pkg.sv]
// Shared constants, types and codes of the command line tokenizer.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package clt_pkg;

  localparam int LINE_BYTES = 64;
  localparam int MAX_WORDS  = 8;

  // Widths that follow from the sizes above.
  localparam int POS_W = $clog2(LINE_BYTES + 1);
  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_WORDS + 1);

  // Widths of the result fields.
  localparam int CHAR_W   = 8;
  localparam int OIDX_W   = 3;
  localparam int OPOS_W   = 7;
  localparam int OTOT_W   = 4;
  localparam int OUTD_W   = 24;
  localparam int OPACK_W  = OIDX_W + 2 * OPOS_W + OTOT_W;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;    // latch the accepted character
    logic step;    // count an ordinary character
    logic finish;  // close the line and start the readout
    logic read;    // fetch the current descriptor
    logic next;    // advance to the next descriptor
  } cmd_t;

  typedef struct packed {
    logic is_nul;
    logic is_end;
    logic last;
  } status_t;

endpackage
`default_nettype wire

[hdl/clt_datapath.sv]
// Datapath of the command line tokenizer: position counters, word table and
// readout registers. Depends on clt_pkg and the assertion macro header.
`default_nettype none
`include "command_line_tokenizer_core_defines.svh"
module clt_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [clt_pkg::CHAR_W-1:0]   in_char,
  input  wire clt_pkg::cmd_t                cmd,
  output clt_pkg::status_t                  status,
  output logic [clt_pkg::OIDX_W-1:0]        word_index,
  output logic [clt_pkg::OPOS_W-1:0]        word_start,
  output logic [clt_pkg::OPOS_W-1:0]        word_length,
  output logic [clt_pkg::OTOT_W-1:0]        word_total,
  output logic                              word_valid
);

  localparam int ENT_W = 2 * clt_pkg::POS_W;

  logic [clt_pkg::CHAR_W-1:0] char_r;
  logic [clt_pkg::POS_W-1:0]  bp_r, bp_nxt;
  logic [clt_pkg::POS_W-1:0]  cur_start_r, cur_start_nxt;
  logic [clt_pkg::IDX_W-1:0]  word_count_r, word_count_nxt;
  logic [clt_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [clt_pkg::IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [ENT_W-1:0]           rd_data_r;

  // Word table: start in the upper half, length in the lower half.
  logic [ENT_W-1:0]           word_mem [clt_pkg::MAX_WORDS];

  logic                       close_word;
  logic [clt_pkg::POS_W-1:0]  run_len;
  logic                       wr_en;
  logic [ENT_W-1:0]           wr_data;

  assign close_word = (char_r == clt_pkg::CH_SPACE) &&
                      (word_count_r < clt_pkg::IDX_W'(clt_pkg::MAX_WORDS - 1));
  // Characters since the current word began; the start never passes the position.
  assign run_len    = bp_r - cur_start_r;

  assign status.is_nul = (char_r == clt_pkg::CH_NUL);
  assign status.is_end = (char_r == clt_pkg::CH_LF) || (char_r == clt_pkg::CH_CR) ||
                         (bp_r == clt_pkg::POS_W'(clt_pkg::LINE_BYTES));
  assign status.last   = (total_r == '0) ||
                         ((clt_pkg::CNT_W'(rd_idx_r) + clt_pkg::CNT_W'(1)) == total_r);

  assign wr_en   = (cmd.step && close_word) || (cmd.finish && (run_len != '0));
  assign wr_data = {cur_start_r, run_len};

  always_comb begin
    bp_nxt         = bp_r;
    cur_start_nxt  = cur_start_r;
    word_count_nxt = word_count_r;
    total_nxt      = total_r;
    rd_idx_nxt     = rd_idx_r;
    if (cmd.step) begin
      bp_nxt = bp_r + clt_pkg::POS_W'(1);
      if (close_word) begin
        word_count_nxt = word_count_r + clt_pkg::IDX_W'(1);
        cur_start_nxt  = bp_r + clt_pkg::POS_W'(1);
      end
    end
    if (cmd.finish) begin
      // A trailing word counts only when it holds characters.
      total_nxt      = clt_pkg::CNT_W'(word_count_r) +
                       clt_pkg::CNT_W'(run_len != '0);
      bp_nxt         = '0;
      cur_start_nxt  = '0;
      word_count_nxt = '0;
      rd_idx_nxt     = '0;
    end
    if (cmd.next) begin
      rd_idx_nxt = rd_idx_r + clt_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r         <= '0;
      cur_start_r  <= '0;
      word_count_r <= '0;
      total_r      <= '0;
      rd_idx_r     <= '0;
    end else begin
      bp_r         <= bp_nxt;
      cur_start_r  <= cur_start_nxt;
      word_count_r <= word_count_nxt;
      total_r      <= total_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[word_count_r] <= wr_data;
    end
    if (cmd.read) begin
      rd_data_r <= word_mem[rd_idx_r];
    end
  end

  // An empty line reads as an all-zero invalid descriptor.
  assign word_valid  = (total_r != '0);
  assign word_index  = clt_pkg::OIDX_W'(rd_idx_r);
  assign word_start  = word_valid ? clt_pkg::OPOS_W'(rd_data_r[ENT_W-1 -: clt_pkg::POS_W])
                                  : '0;
  assign word_length = word_valid ? clt_pkg::OPOS_W'(rd_data_r[clt_pkg::POS_W-1:0]) : '0;
  assign word_total  = clt_pkg::OTOT_W'(total_r);

  `CLT_ASSERT(a_pos_bound, clk, rst_n,
    bp_r <= clt_pkg::POS_W'(clt_pkg::LINE_BYTES), "line position beyond buffer")
  `CLT_ASSERT(a_start_le_pos, clk, rst_n,
    cur_start_r <= bp_r, "word start ahead of line position")
  `CLT_ASSERT(a_finish_clears, clk, rst_n,
    cmd.finish |=> (bp_r == '0) && (word_count_r == '0) && (rd_idx_r == '0),
    "line state not cleared after line end")

endmodule
`default_nettype wire

[hdl/clt_controller.sv]
// Controller of the command line tokenizer: sequences character intake,
// line end and descriptor readout. Depends on clt_pkg and the macro header.
`default_nettype none
`include "command_line_tokenizer_core_defines.svh"
module clt_controller (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire clt_pkg::status_t  status,
  output clt_pkg::cmd_t          cmd
);

  clt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      clt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = clt_pkg::ST_DECODE;
        end
      end
      clt_pkg::ST_DECODE: begin
        priority if (status.is_nul) begin
          state_nxt = clt_pkg::ST_IDLE;
        end else if (status.is_end) begin
          cmd.finish = 1'b1;
          state_nxt  = clt_pkg::ST_READ;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = clt_pkg::ST_IDLE;
        end
      end
      clt_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = clt_pkg::ST_SEND;
      end
      clt_pkg::ST_SEND: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (status.last) begin
            state_nxt = clt_pkg::ST_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = clt_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = clt_pkg::ST_IDLE;
    endcase
  end

  `CLT_ASSERT_ALWAYS(a_one_side, clk, !(in_tready && out_tvalid),
    "input and output open at once")
  `CLT_ASSERT(a_end_reads, clk, rst_n,
    (state_r == clt_pkg::ST_DECODE) && !status.is_nul && status.is_end
      |=> state_r == clt_pkg::ST_READ,
    "line end did not start the readout")
  `CLT_ASSERT(a_last_idles, clk, rst_n,
    out_tvalid && out_tready && status.last |=> state_r == clt_pkg::ST_IDLE,
    "readout continued past the final beat")

endmodule
`default_nettype wire

[hdl/command_line_tokenizer_core.sv]
// Command line tokenizer: takes one character per beat and, at each line end
// (CR, LF, or a character arriving with the 64-byte buffer full), sends one
// start/length descriptor per word, up to 8, or one invalid beat for an empty
// line. NUL is dropped. For each input beat the character is registered first,
// then the position counter and the word table are updated. Each descriptor is
// fetched from the word table by a registered read before it is sent; no input
// is taken while a line is being read out.
// Depends on clt_pkg, clt_controller and clt_datapath.
`default_nettype none
module command_line_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] word_index, [9:3] word_start,
                                       // [16:10] word_length, [20:17] word_total,
                                       // [23:21] zero
  output logic             out_tuser,  // word_valid
  output logic             out_tlast   // last_word
);

  clt_pkg::cmd_t                  cmd;
  clt_pkg::status_t               status;
  logic [clt_pkg::OIDX_W-1:0]     word_index;
  logic [clt_pkg::OPOS_W-1:0]     word_start;
  logic [clt_pkg::OPOS_W-1:0]     word_length;
  logic [clt_pkg::OTOT_W-1:0]     word_total;

  clt_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  clt_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_char     (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .word_index  (word_index),
    .word_start  (word_start),
    .word_length (word_length),
    .word_total  (word_total),
    .word_valid  (out_tuser)
  );

  assign out_tdata = {{(clt_pkg::OUTD_W - clt_pkg::OPACK_W){1'b0}},
                      word_total, word_length, word_start, word_index};
  assign out_tlast = status.last;

endmodule
`default_nettype wire
